[hdl/frs_pkg.sv]
// ----------------------------------------------------------------------------
// frs_pkg
// Shared codes, widths and control/status bundles of the frame ring store.
// ----------------------------------------------------------------------------
package frs_pkg;

  localparam int CMD_W      = 2;
  localparam int BYTE_W     = 8;
  localparam int KIND_W     = 3;
  localparam int LEN_OUT_W  = 7;
  localparam int OUT_DATA_W = 16;
  localparam int CFG_W      = 9;
  localparam int RING_MIN   = 3;

  localparam logic [CFG_W-1:0] CFG_RST = 9'd256;

  localparam logic [CMD_W-1:0] CMD_ADD   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_NEXT  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_CUR   = 2'd2;
  localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd3;

  localparam logic [KIND_W-1:0] K_ADD_DONE = 3'd0;
  localparam logic [KIND_W-1:0] K_BYTE     = 3'd1;
  localparam logic [KIND_W-1:0] K_NO_FRAME = 3'd2;
  localparam logic [KIND_W-1:0] K_EMPTY    = 3'd3;
  localparam logic [KIND_W-1:0] K_CLEARED  = 3'd4;
  localparam logic [KIND_W-1:0] K_OVERFLOW = 3'd5;

  typedef struct packed {
    logic take;     // input item accepted this cycle
    logic sweep;    // zero one length entry
    logic len_rd;   // read length of current slot
    logic chk;      // evaluate length just read
    logic emit;     // push next frame byte to output stage
    logic res;      // push pending single result to output stage
  } frs_cmd_t;

  typedef struct packed {
    logic cur_eq;      // cursors equal
    logic sweep_last;  // sweep at final slot
    logic len_zero;    // length read is zero
    logic emit_last;   // byte in flight is the frame's last
    logic out_free;    // output stage can load this cycle
  } frs_stat_t;

endpackage

[hdl/frs_ctrl.sv]
// ----------------------------------------------------------------------------
// frs_ctrl
// Sequencer: accepts items, runs clear sweeps and frame read-out.
// ----------------------------------------------------------------------------
module frs_ctrl (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_tvalid,
  input  logic [frs_pkg::CMD_W-1:0] in_tuser,
  input  logic                    in_tlast,
  output logic                    in_tready,
  input  frs_pkg::frs_stat_t      stat,
  output frs_pkg::frs_cmd_t       cmd
);
  import frs_pkg::*;

  localparam logic [2:0] S_INIT = 3'd0;
  localparam logic [2:0] S_IDLE = 3'd1;
  localparam logic [2:0] S_CLR  = 3'd2;
  localparam logic [2:0] S_RES  = 3'd3;
  localparam logic [2:0] S_LEN  = 3'd4;
  localparam logic [2:0] S_CHK  = 3'd5;
  localparam logic [2:0] S_EMIT = 3'd6;

  logic [2:0] state_r, state_nxt;
  logic       take;

  assign in_tready = (state_r == S_IDLE);
  assign take      = in_tvalid && in_tready;

  always_comb begin
    cmd        = '0;
    cmd.take   = take;
    cmd.sweep  = (state_r == S_INIT) || (state_r == S_CLR);
    cmd.len_rd = (state_r == S_LEN);
    cmd.chk    = (state_r == S_CHK);
    cmd.emit   = (state_r == S_EMIT);
    cmd.res    = (state_r == S_RES);
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_INIT: if (stat.sweep_last) state_nxt = S_IDLE;
      S_IDLE: begin
        if (take) begin
          case (in_tuser)
            CMD_ADD:   state_nxt = in_tlast ? S_RES : S_IDLE;
            CMD_NEXT:  state_nxt = stat.cur_eq ? S_RES : S_LEN;
            CMD_CUR:   state_nxt = S_LEN;
            CMD_CLEAR: state_nxt = S_CLR;
            default:   state_nxt = S_IDLE;
          endcase
        end
      end
      S_CLR:  if (stat.sweep_last) state_nxt = S_RES;
      S_RES:  if (stat.out_free) state_nxt = S_IDLE;
      S_LEN:  state_nxt = S_CHK;
      S_CHK:  state_nxt = stat.len_zero ? S_RES : S_EMIT;
      S_EMIT: if (stat.out_free && stat.emit_last) state_nxt = S_IDLE;
      default: state_nxt = S_INIT;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_INIT;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

[hdl/frs_dp.sv]
// ----------------------------------------------------------------------------
// frs_dp
// Datapath: cursors, fill state, length and byte memories, output stage.
// ----------------------------------------------------------------------------
module frs_dp #(
  parameter int SLOTS       = 256,
  parameter int FRAME_BYTES = 64
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_valid,
  input  logic [frs_pkg::CFG_W-1:0]     cfg_data,
  input  logic [frs_pkg::CMD_W-1:0]     in_tuser,
  input  logic [frs_pkg::BYTE_W-1:0]    in_tdata,
  input  logic                          in_tlast,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [frs_pkg::OUT_DATA_W-1:0] out_tdata,
  output logic [frs_pkg::KIND_W-1:0]    out_tuser,
  output logic                          out_tlast,
  input  frs_pkg::frs_cmd_t             cmd,
  output frs_pkg::frs_stat_t            stat
);
  import frs_pkg::*;

  localparam int CW     = (SLOTS > 2) ? $clog2(SLOTS) : 1;
  localparam int RW     = $clog2(SLOTS + 1);
  localparam int CMPW   = (RW > CFG_W) ? RW : CFG_W;
  localparam int LW     = $clog2(FRAME_BYTES + 1);
  localparam int BW     = (FRAME_BYTES > 1) ? $clog2(FRAME_BYTES) : 1;
  localparam int BDEPTH = SLOTS * (1 << BW);

  logic [CFG_W-1:0]  slots_r;
  logic [CMPW-1:0]   ring;
  logic [CW-1:0]     wr_r, rd_r, cnt_r;
  logic [CW-1:0]     wr_adv, rd_adv;
  logic [LW-1:0]     fill_r, fill_inc;
  logic              ovf_r, ovf_new, first, room;
  logic [LW-1:0]     len_mem [SLOTS];
  logic [BYTE_W-1:0] byte_mem [BDEPTH];
  logic [LW-1:0]     len_rd_r, emit_len_r, k_r;
  logic [KIND_W-1:0] pend_kind_r;
  logic [LW-1:0]     pend_len_r;
  logic              out_valid_r;
  logic [KIND_W-1:0] out_kind_r;
  logic [LW-1:0]     out_len_r;
  logic              out_last_r;
  logic [BYTE_W-1:0] rd_byte_r;
  logic              adv, emit_go, is_add, is_next, is_clr;
  logic              len_we;
  logic [CW-1:0]     len_wa;
  logic [LW-1:0]     len_wd;

  function automatic logic [CW-1:0] step_f(input logic [CW-1:0] c,
                                           input logic [CMPW-1:0] n);
    logic [CMPW-1:0] p;
    p = CMPW'(c) + 1'b1;
    return (p >= n) ? '0 : p[CW-1:0];
  endfunction

  always_comb begin
    if (CMPW'(slots_r) > CMPW'(SLOTS)) begin
      ring = CMPW'(SLOTS);
    end else if (CMPW'(slots_r) < CMPW'(RING_MIN)) begin
      ring = CMPW'(RING_MIN);
    end else begin
      ring = CMPW'(slots_r);
    end
  end

  assign wr_adv   = step_f(wr_r, ring);
  assign rd_adv   = step_f(rd_r, ring);
  assign is_add   = cmd.take && (in_tuser == CMD_ADD);
  assign is_next  = cmd.take && (in_tuser == CMD_NEXT);
  assign is_clr   = cmd.take && (in_tuser == CMD_CLEAR);
  assign first    = (fill_r == '0) && !ovf_r;
  assign room     = fill_r < LW'(FRAME_BYTES);
  assign fill_inc = room ? LW'(fill_r + 1'b1) : fill_r;
  assign ovf_new  = ovf_r || !room;
  assign adv      = !out_valid_r || out_tready;
  assign emit_go  = cmd.emit && adv;

  assign stat.cur_eq     = (wr_r == rd_r);
  assign stat.sweep_last = (cnt_r == CW'(SLOTS - 1));
  assign stat.len_zero   = (len_rd_r == '0);
  assign stat.emit_last  = (LW'(k_r + 1'b1) == emit_len_r);
  assign stat.out_free   = adv;

  always_comb begin
    len_we = 1'b0;
    len_wa = wr_r;
    len_wd = '0;
    if (cmd.sweep) begin
      len_we = 1'b1;
      len_wa = cnt_r;
    end else if (is_add && in_tlast) begin
      len_we = 1'b1;
      len_wd = fill_inc;
    end else if (is_add && first) begin
      len_we = 1'b1;
    end else if (is_next && !stat.cur_eq) begin
      len_we = 1'b1;
      len_wa = rd_r;
    end
  end

  always_ff @(posedge clk) begin
    if (len_we) begin
      len_mem[len_wa] <= len_wd;
    end
    if (cmd.len_rd) begin
      len_rd_r <= len_mem[rd_r];
    end
  end

  always_ff @(posedge clk) begin
    if (is_add && room) begin
      byte_mem[{wr_r, fill_r[BW-1:0]}] <= in_tdata;
    end
    if (emit_go) begin
      rd_byte_r <= byte_mem[{rd_r, k_r[BW-1:0]}];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slots_r <= CFG_RST;
    end else if (cfg_valid) begin
      slots_r <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r   <= CW'(1);
      rd_r   <= '0;
      fill_r <= '0;
      ovf_r  <= 1'b0;
      cnt_r  <= '0;
    end else begin
      if (cmd.sweep) begin
        cnt_r <= stat.sweep_last ? '0 : CW'(cnt_r + 1'b1);
      end
      if (is_clr) begin
        wr_r   <= CW'(1);
        rd_r   <= '0;
        fill_r <= '0;
        ovf_r  <= 1'b0;
        cnt_r  <= '0;
      end else if (is_add) begin
        if (in_tlast) begin
          fill_r <= '0;
          ovf_r  <= 1'b0;
          wr_r   <= wr_adv;
          if (wr_adv == rd_r) begin
            rd_r <= rd_adv;
          end
        end else begin
          fill_r <= fill_inc;
          ovf_r  <= ovf_new;
        end
      end else if (is_next && !stat.cur_eq) begin
        rd_r <= rd_adv;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (is_add && in_tlast) begin
      pend_kind_r <= ovf_new ? K_OVERFLOW : K_ADD_DONE;
      pend_len_r  <= fill_inc;
    end else if (is_next && stat.cur_eq) begin
      pend_kind_r <= K_EMPTY;
      pend_len_r  <= '0;
    end else if (is_clr) begin
      pend_kind_r <= K_CLEARED;
      pend_len_r  <= '0;
    end else if (cmd.chk) begin
      pend_kind_r <= K_NO_FRAME;
      pend_len_r  <= '0;
    end
    if (cmd.chk) begin
      emit_len_r <= len_rd_r;
      k_r        <= '0;
    end else if (emit_go) begin
      k_r <= LW'(k_r + 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if ((cmd.res || cmd.emit) && adv) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.res && adv) begin
      out_kind_r <= pend_kind_r;
      out_len_r  <= pend_len_r;
      out_last_r <= 1'b1;
    end else if (emit_go) begin
      out_kind_r <= K_BYTE;
      out_len_r  <= emit_len_r;
      out_last_r <= stat.emit_last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_kind_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = {1'b0, LEN_OUT_W'(out_len_r),
                       (out_kind_r == K_BYTE) ? rd_byte_r : '0};

endmodule

[hdl/frame_ring_store_overwrite.sv]
// ----------------------------------------------------------------------------
// frame_ring_store_overwrite
// Ring of frame slots, oldest frame overwritten when the ring fills.
// ----------------------------------------------------------------------------
// Input channel in_*: tuser = command, tdata = frame byte, tlast = final byte.
// Output channel out_*: tuser = result kind, tdata = byte and frame length,
// tlast = final result of the input item.
// cfg_* writes slots_in_use; cfg_ready is always high.
// An add byte that is not final gives no result; after a final byte its
// result loads into the output stage once that stage is free.
// Next/current: the length memory is read and the length checked, then the
// frame's bytes follow one per cycle from the byte memory read port while the output stage can load.
// Clear: zeroes all SLOTS entries of the length memory one slot per cycle, then
// reports. After reset the same sweep runs with in_tready low.
// When the receiver stalls, the output stage holds its item; a new input
// item is taken while a finished single result waits, and the byte stream
// pauses until out_tready returns.
// ----------------------------------------------------------------------------
module frame_ring_store_overwrite #(
  parameter int SLOTS       = 256,
  parameter int FRAME_BYTES = 64
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [frs_pkg::CFG_W-1:0]      cfg_data,   // slots_in_use
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [frs_pkg::BYTE_W-1:0]     in_tdata,   // [7:0] data_byte
  input  logic [frs_pkg::CMD_W-1:0]      in_tuser,   // [1:0] command
  input  logic                           in_tlast,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [frs_pkg::OUT_DATA_W-1:0] out_tdata,  // [7:0] out_byte, [14:8] frame_length
  output logic [frs_pkg::KIND_W-1:0]     out_tuser,  // [2:0] kind
  output logic                           out_tlast
);
  import frs_pkg::*;

  frs_cmd_t  cmd;
  frs_stat_t stat;

  assign cfg_ready = 1'b1;

  frs_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tuser  (in_tuser),
    .in_tlast  (in_tlast),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  frs_dp #(
    .SLOTS       (SLOTS),
    .FRAME_BYTES (FRAME_BYTES)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_data   (cfg_data),
    .in_tuser   (in_tuser),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cmd        (cmd),
    .stat       (stat)
  );

endmodule

[hdl/frs_chk.sv]
// ----------------------------------------------------------------------------
// frs_chk
// Port-level checks of the frame ring store, bound to the top level.
// ----------------------------------------------------------------------------
module frs_chk (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_tready,
  input logic                           out_tvalid,
  input logic                           out_tready,
  input logic [frs_pkg::OUT_DATA_W-1:0] out_tdata,
  input logic [frs_pkg::KIND_W-1:0]     out_tuser,
  input logic                           out_tlast
);
  import frs_pkg::*;

  a_rst_sweep: assert property (@(posedge clk) !rst_n |=> !in_tready)
    else $error("input ready right after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata)
      && $stable(out_tuser) && $stable(out_tlast))
    else $error("stalled output item changed");

  a_byte_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser != K_BYTE |-> out_tdata[7:0] == 8'd0 && out_tlast)
    else $error("single result with byte or not last");

  a_byte_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == K_BYTE |-> out_tdata[14:8] != 7'd0)
    else $error("frame byte with zero length");

endmodule

bind frame_ring_store_overwrite frs_chk u_frs_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);
